// ===== rtl/ifd_pkg.sv =====
// Package: widths, codes, register indexes and shared types of the interleaved frame deframer.
`default_nettype none

package ifd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned EVT_W   = 3;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned KIND_W  = 2;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [BYTE_W-1:0] MARKER_BYTE       = 8'h24;
    localparam logic [BYTE_W-1:0] RST_MAX_CHANNEL   = 8'd2;
    localparam logic [LEN_W-1:0]  RST_MAX_LENGTH    = 16'd1600;
    localparam logic [CNT_W-1:0]  RST_ATTEMPT_LIMIT = 16'd10000;

    localparam logic [PHASE_W-1:0] PH_HUNT    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CHAN    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN_HI  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEN_LO  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;

    localparam logic [EVT_W-1:0] EV_DATA    = 3'd0;
    localparam logic [EVT_W-1:0] EV_TOKEN   = 3'd1;
    localparam logic [EVT_W-1:0] EV_CHANNEL = 3'd2;
    localparam logic [EVT_W-1:0] EV_LENGTH  = 3'd3;
    localparam logic [EVT_W-1:0] EV_SYNC    = 3'd4;

    localparam logic [KIND_W-1:0] K_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] K_TOKEN = 2'd1;
    localparam logic [KIND_W-1:0] K_CHAN  = 2'd2;
    localparam logic [KIND_W-1:0] K_LEN   = 2'd3;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;
    localparam logic [1:0] REG_MAX_CHANNEL   = 2'd0;
    localparam logic [1:0] REG_MAX_LENGTH    = 2'd1;
    localparam logic [1:0] REG_ATTEMPT_LIMIT = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] chan;
        logic              last;
    } t_ifd_rec;

    typedef struct packed {
        logic [BYTE_W-1:0] max_channel;
        logic [LEN_W-1:0]  max_length;
        logic [CNT_W-1:0]  attempt_limit;
    } t_ifd_cfg;

endpackage

`default_nettype wire

// ===== rtl/ifd_if.sv =====
// Interfaces: byte input channel and event output channel.
`default_nettype none

interface ifd_in_if;
    import ifd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface ifd_out_if;
    import ifd_pkg::*;
    logic              valid;
    logic              ready;
    logic [EVT_W-1:0]  event_res;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] frame_channel;
    logic              last_of_frame;
    modport source (output valid, output event_res, output data_byte,
                    output frame_channel, output last_of_frame, input ready);
    modport sink (input valid, input event_res, input data_byte,
                  input frame_channel, input last_of_frame, output ready);
endinterface

`default_nettype wire

// ===== rtl/ifd_front.sv =====
// Front end: header parser that classifies each byte and pushes result records.
`default_nettype none

module ifd_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    ifd_in_if.sink            i_in,
    input  ifd_pkg::t_ifd_cfg i_cfg,
    input  wire               i_q_full,
    output logic              o_push,
    output ifd_pkg::t_ifd_rec o_rec
);
    import ifd_pkg::*;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [BYTE_W-1:0]  r_chan, n_chan;
    logic [BYTE_W-1:0]  r_len_hi, n_len_hi;
    logic [LEN_W-1:0]   r_rem, n_rem;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W-1:0]  b;
    logic               acc;
    logic               push;
    t_ifd_rec           rec;

    assign i_in.ready = !i_q_full;
    assign acc        = i_in.valid && i_in.ready;
    assign b          = i_in.in_byte;
    assign len        = {r_len_hi, b};

    always_comb begin
        n_phase  = r_phase;
        n_chan   = r_chan;
        n_len_hi = r_len_hi;
        n_rem    = r_rem;
        push     = 1'b0;
        rec      = '{kind: K_DATA, data: '0, chan: '0, last: 1'b0};
        case (r_phase)
            PH_CHAN: begin
                if (b > i_cfg.max_channel) begin
                    push     = 1'b1;
                    rec.kind = K_CHAN;
                    rec.chan = b;
                    n_phase  = PH_HUNT;
                end else begin
                    n_chan  = b;
                    n_phase = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                n_len_hi = b;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (len == '0 || len > i_cfg.max_length) begin
                    push     = 1'b1;
                    rec.kind = K_LEN;
                    rec.chan = r_chan;
                    n_phase  = PH_HUNT;
                end else begin
                    n_rem   = len;
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                push     = 1'b1;
                rec.data = b;
                rec.chan = r_chan;
                if (r_rem <= LEN_W'(1)) begin
                    rec.last = 1'b1;
                    n_rem    = '0;
                    n_phase  = PH_HUNT;
                end else begin
                    n_rem = r_rem - LEN_W'(1);
                end
            end
            default: begin
                if (b == MARKER_BYTE) begin
                    n_phase = PH_CHAN;
                end else begin
                    push     = 1'b1;
                    rec.kind = K_TOKEN;
                    n_phase  = PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_chan   <= '0;
            r_len_hi <= '0;
            r_rem    <= '0;
        end else if (acc) begin
            r_phase  <= n_phase;
            r_chan   <= n_chan;
            r_len_hi <= n_len_hi;
            r_rem    <= n_rem;
        end
    end

    assign o_push = acc && push;
    assign o_rec  = rec;

endmodule

`default_nettype wire

// ===== rtl/ifd_queue.sv =====
// Short record queue between the parser and the event stage.
`default_nettype none

module ifd_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  ifd_pkg::t_ifd_rec i_rec,
    input  wire               i_pop,
    output logic              o_full,
    output logic              o_valid,
    output ifd_pkg::t_ifd_rec o_rec
);
    import ifd_pkg::*;

    t_ifd_rec          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ifd_back.sv =====
// Back end: attempt counting, event encoding and the output register.
`default_nettype none

module ifd_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  ifd_pkg::t_ifd_cfg i_cfg,
    input  wire               i_q_valid,
    input  ifd_pkg::t_ifd_rec i_rec,
    output logic              o_pop,
    ifd_out_if.source         o_out
);
    import ifd_pkg::*;

    logic              r_valid;
    logic [EVT_W-1:0]  r_event, n_event;
    logic [BYTE_W-1:0] r_data, n_data;
    logic [BYTE_W-1:0] r_chan, n_chan;
    logic              r_last, n_last;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W:0]    next_count;
    logic              sync;
    logic              load;

    assign load       = i_q_valid && (!r_valid || o_out.ready);
    assign next_count = {1'b0, r_count} + (CNT_W+1)'(1);
    assign sync       = next_count >= {1'b0, i_cfg.attempt_limit};

    always_comb begin
        n_count = r_count;
        n_event = EV_DATA;
        n_data  = '0;
        n_chan  = i_rec.chan;
        n_last  = 1'b0;
        case (i_rec.kind)
            K_DATA: begin
                n_data = i_rec.data;
                n_last = i_rec.last;
                if (i_rec.last) begin
                    n_count = '0;
                end
            end
            K_TOKEN, K_CHAN, K_LEN: begin
                if (sync) begin
                    n_count = '0;
                    n_event = EV_SYNC;
                    n_chan  = '0;
                end else begin
                    n_count = next_count[CNT_W-1:0];
                    case (i_rec.kind)
                        K_TOKEN: n_event = EV_TOKEN;
                        K_CHAN:  n_event = EV_CHANNEL;
                        default: n_event = EV_LENGTH;
                    endcase
                end
            end
            default: begin
                n_event = EV_DATA;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_count <= n_count;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_event <= n_event;
            r_data  <= n_data;
            r_chan  <= n_chan;
            r_last  <= n_last;
        end
    end

    assign o_pop               = load;
    assign o_out.valid         = r_valid;
    assign o_out.event_res     = r_event;
    assign o_out.data_byte     = r_data;
    assign o_out.frame_channel = r_chan;
    assign o_out.last_of_frame = r_last;

    a_reject_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_event != EV_DATA |-> r_data == '0 && !r_last)
        else $error("rejection event carries payload");

    a_last_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && i_rec.kind == K_DATA && i_rec.last |=> r_count == '0)
        else $error("attempt count not cleared after complete frame");

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && i_rec.kind != K_DATA |=>
        r_count == '0 || r_count == $past(r_count) + CNT_W'(1))
        else $error("attempt count moved by more than one");

    a_sync_no_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_event == EV_SYNC |-> r_chan == '0 && r_count == '0)
        else $error("sync-lost event with channel or live count");

endmodule

`default_nettype wire

// ===== rtl/interleaved_frame_deframer_top.sv =====
// Top level of the interleaved frame deframer: register port, parser, queue and event stage.
// Accepts one stream byte per cycle unless the queue is full. A byte that gives a result
// (payload byte or rejection) is pushed into a four-entry record queue at the edge it is
// accepted and is then loaded from the queue into the output register; header bytes that
// give no result only advance the parser. The input is held off only while the queue is
// full, which takes five undelivered results while the output side stalls: one on the
// output register and four in the queue. Registers: max_channel at 0x0, max_length at
// 0x4, attempt_limit at 0x8; write them only while no item is in flight.
`default_nettype none

module interleaved_frame_deframer_top (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    ifd_in_if.sink                      i_in,
    ifd_out_if.source                   o_out,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [ifd_pkg::PADDR_W-1:0]  paddr,
    input  wire [ifd_pkg::PDATA_W-1:0]  pwdata,
    output logic [ifd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import ifd_pkg::*;

    t_ifd_cfg   r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;
    logic       q_full;
    logic       q_valid;
    logic       push;
    logic       pop;
    t_ifd_rec   push_rec;
    t_ifd_rec   pop_rec;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_channel   <= RST_MAX_CHANNEL;
            r_cfg.max_length    <= RST_MAX_LENGTH;
            r_cfg.attempt_limit <= RST_ATTEMPT_LIMIT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MAX_CHANNEL:   r_cfg.max_channel   <= pwdata[BYTE_W-1:0];
                REG_MAX_LENGTH:    r_cfg.max_length    <= pwdata[LEN_W-1:0];
                REG_ATTEMPT_LIMIT: r_cfg.attempt_limit <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MAX_CHANNEL:   prdata = PDATA_W'(r_cfg.max_channel);
            REG_MAX_LENGTH:    prdata = PDATA_W'(r_cfg.max_length);
            REG_ATTEMPT_LIMIT: prdata = PDATA_W'(r_cfg.attempt_limit);
            default:           prdata = '0;
        endcase
    end

    ifd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_rec    (push_rec)
    );

    ifd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (pop_rec)
    );

    ifd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_rec     (pop_rec),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
